>>> sv/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// shared types and constants of the server load table
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

  localparam int unsigned DEFAULT_DEPTH = 16;
  localparam int unsigned OP_W          = 2;
  localparam int unsigned STAT_W        = 2;
  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned LOAD_W        = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_SET    = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_ABSENT = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

endpackage : slt_pkg

`default_nettype wire

>>> sv/slt_ram.sv
// ----------------------------------------------------------------------------
// slt_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module slt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule : slt_ram

`default_nettype wire

>>> sv/server_load_table_core.sv
// ----------------------------------------------------------------------------
// server_load_table_core
// ordered table of (ipv4 address, q16.16 load) entries with add, remove,
// get and set, driven by one address compare unit under a small sequencer
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one command item: tuser = operation, tdata = address and
//   load. m_axis returns one result item per command: tuser = status,
//   tdata = load (nonzero only for a successful get).
//   s_axis_tready is high only while the sequencer is idle; one command is
//   worked on at a time.
// sequence, accept to result valid:
//   add                 dispatch writes the new entry on top unless full, then resp
//   get / set           dispatch, then a top-down scan that
//                       reads one entry a cycle through the ram read port, then resp
//   remove              the same scan, then a shift over every entry above the match,
//                       the compaction moving one entry a cycle
//                       through the same port, then resp
//   on an empty table, get, set and remove go from dispatch straight to resp
// the result sits in an output register; a new command can be taken while
// it waits, and the sequencer holds its next result in resp until that one
// is taken.
// reset empties the table at once (entry count to zero, no clearing pass)
// and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module server_load_table_core
  import slt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // command items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // [31:0] server_address, [63:32] load_value
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] operation
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,  // [31:0] load_out
  output logic      [1:0]  m_axis_tuser   // [1:0] status
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [ADDR_W-1:0] key_q, key_d;
  logic [LOAD_W-1:0] load_q, load_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     rd_idx_q, rd_idx_d;
  logic              issued_all_q, issued_all_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]     cmp_idx_q, cmp_idx_d;
  logic [CW-1:0]     sh_rd_q, sh_rd_d;
  logic              mv_vld_q, mv_vld_d;
  logic [AW-1:0]     mv_wr_q, mv_wr_d;
  status_e           res_status_q, res_status_d;
  logic [LOAD_W-1:0] res_load_q, res_load_d;
  logic              m_valid_q, m_valid_d;
  status_e           m_status_q, m_status_d;
  logic [LOAD_W-1:0] m_load_q, m_load_d;

  logic              addr_we, load_we;
  logic [AW-1:0]     waddr, raddr;
  logic [ADDR_W-1:0] addr_wdata, addr_rdata;
  logic [LOAD_W-1:0] load_wdata, load_rdata;
  logic              hit;

  slt_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (addr_we),
    .waddr_i (waddr),
    .wdata_i (addr_wdata),
    .raddr_i (raddr),
    .rdata_o (addr_rdata)
  );

  slt_ram #(
    .WIDTH (LOAD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_load_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (waddr),
    .wdata_i (load_wdata),
    .raddr_i (raddr),
    .rdata_o (load_rdata)
  );

  // the shared compare unit
  assign hit = cmp_vld_q && (addr_rdata == key_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      issued_all_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      mv_vld_q     <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      issued_all_q <= issued_all_d;
      cmp_vld_q    <= cmp_vld_d;
      mv_vld_q     <= mv_vld_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    load_q       <= load_d;
    rd_idx_q     <= rd_idx_d;
    cmp_idx_q    <= cmp_idx_d;
    sh_rd_q      <= sh_rd_d;
    mv_wr_q      <= mv_wr_d;
    res_status_q <= res_status_d;
    res_load_q   <= res_load_d;
    m_status_q   <= m_status_d;
    m_load_q     <= m_load_d;
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    load_d       = load_q;
    count_d      = count_q;
    rd_idx_d     = rd_idx_q;
    issued_all_d = issued_all_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_idx_d    = cmp_idx_q;
    sh_rd_d      = sh_rd_q;
    mv_vld_d     = mv_vld_q;
    mv_wr_d      = mv_wr_q;
    res_status_d = res_status_q;
    res_load_d   = res_load_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_status_d   = m_status_q;
    m_load_d     = m_load_q;

    addr_we    = 1'b0;
    load_we    = 1'b0;
    waddr      = '0;
    raddr      = '0;
    addr_wdata = key_q;
    load_wdata = load_q;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = op_e'(s_axis_tuser);
          key_d   = s_axis_tdata[31:0];
          load_d  = s_axis_tdata[63:32];
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_load_d = '0;
        if (op_q == OP_ADD) begin
          if (count_q == FULL_COUNT) begin
            res_status_d = STAT_FULL;
          end else begin
            addr_we      = 1'b1;
            load_we      = 1'b1;
            waddr        = count_q[AW-1:0];
            count_d      = count_q + 1'b1;
            res_status_d = STAT_OK;
          end
          state_d = S_RESP;
        end else if (count_q == '0) begin
          res_status_d = (op_q == OP_REMOVE) ? STAT_EMPTY : STAT_ABSENT;
          state_d      = S_RESP;
        end else begin
          rd_idx_d     = AW'(count_q - 1'b1);
          issued_all_d = 1'b0;
          cmp_vld_d    = 1'b0;
          state_d      = S_SCAN;
        end
      end

      // newest first: reads go out from the top, each compared in the cycle after its read
      S_SCAN: begin
        raddr = rd_idx_q;
        if (hit) begin
          cmp_vld_d    = 1'b0;
          res_status_d = STAT_OK;
          case (op_q)
            OP_GET: begin
              res_load_d = load_rdata;
              state_d    = S_RESP;
            end
            OP_SET: begin
              load_we = 1'b1;
              waddr   = cmp_idx_q;
              state_d = S_RESP;
            end
            default: begin
              sh_rd_d  = CW'(cmp_idx_q) + 1'b1;
              mv_vld_d = 1'b0;
              state_d  = S_SHIFT;
            end
          endcase
        end else if (cmp_vld_q && (cmp_idx_q == '0)) begin
          cmp_vld_d    = 1'b0;
          res_status_d = STAT_ABSENT;
          state_d      = S_RESP;
        end else begin
          cmp_vld_d = !issued_all_q;
          cmp_idx_d = rd_idx_q;
          if (rd_idx_q == '0) begin
            issued_all_d = 1'b1;
          end else begin
            rd_idx_d = rd_idx_q - 1'b1;
          end
        end
      end

      // close the gap: read slot j+1, write it to slot j in the next cycle
      S_SHIFT: begin
        if (mv_vld_q) begin
          addr_we    = 1'b1;
          load_we    = 1'b1;
          waddr      = mv_wr_q;
          addr_wdata = addr_rdata;
          load_wdata = load_rdata;
        end
        if (sh_rd_q != count_q) begin
          raddr    = sh_rd_q[AW-1:0];
          mv_vld_d = 1'b1;
          mv_wr_d  = AW'(sh_rd_q - 1'b1);
          sh_rd_d  = sh_rd_q + 1'b1;
        end else begin
          mv_vld_d = 1'b0;
          count_d  = count_q - 1'b1;
          state_d  = S_RESP;
        end
      end

      S_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_load_d   = res_load_q;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_load_q;
  assign m_axis_tuser  = m_status_q;

  // entry count stays within the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_COUNT)
    else $error("entry count beyond table depth");

  // the count moves by at most one per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1) ||
             (count_q == $past(count_q) - 1'b1))
    else $error("entry count jumped");

  // one command at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command taken while busy");

  // only a successful get returns a load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata != '0) |-> (m_axis_tuser == STAT_OK))
    else $error("nonzero load with failing status");

  // full is reported only against a full table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) && (res_status_q == STAT_FULL) |-> (count_q == FULL_COUNT))
    else $error("full status with room left");

endmodule : server_load_table_core

`default_nettype wire
